FILE: rtl/atw_pkg.sv
// Shared types, codes and constants for the translation table walker.
// No dependencies; every other file in rtl uses this package.
package atw_pkg;

    localparam int PA_BITS_DEFAULT = 48;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_LOW_GRANULE  = 2'd0;
    localparam logic [1:0] REG_HIGH_GRANULE = 2'd1;
    localparam logic [1:0] REG_LOW_OFFSET   = 2'd2;
    localparam logic [1:0] REG_HIGH_OFFSET  = 2'd3;

    localparam logic [1:0] GRAN_4K  = 2'd0;
    localparam logic [1:0] GRAN_64K = 2'd1;

    localparam logic       ACT_REQUEST = 1'b0;
    localparam logic       ACT_DATA    = 1'b1;

    localparam logic [1:0] DESC_TABLE = 2'b11;
    localparam logic [1:0] DESC_BLOCK = 2'b01;

    localparam logic [6:0] VA_WIDTH_4K_3LVL  = 7'd39;
    localparam logic [6:0] VA_WIDTH_64K_2LVL = 7'd42;

    localparam logic [5:0] SIZE_OFFSET_RESET = 6'd25;

    localparam logic [2:0] PS_4K   = 3'd0;
    localparam logic [2:0] PS_64K  = 3'd1;
    localparam logic [2:0] PS_2M   = 3'd2;
    localparam logic [2:0] PS_512M = 3'd3;
    localparam logic [2:0] PS_1G   = 3'd4;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

    typedef struct packed {
        logic        action;
        logic [63:0] virt_addr;
        logic [47:0] table_base;
        logic [63:0] read_data;
        logic        read_error;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] read_address;
        logic [47:0] phys_addr;
        logic [2:0]  page_size;
    } t_out_item;

    typedef struct packed {
        logic [1:0] low_granule;
        logic [1:0] high_granule;
        logic [5:0] low_size_offset;
        logic [5:0] high_size_offset;
    } t_cfg;

    typedef struct packed {
        logic        busy;
        logic [63:0] vaddr;
        logic        granule;
        logic [1:0]  level;
    } t_walk;

endpackage

FILE: rtl/atw_regs.sv
// Configuration register file behind the APB-style port.
// Depends on atw_pkg for register indexes, reset values and the t_cfg type.
module atw_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [atw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [atw_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [atw_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output atw_pkg::t_cfg                   o_cfg
);

    atw_pkg::t_cfg r_cfg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_granule      <= atw_pkg::GRAN_4K;
            r_cfg.high_granule     <= atw_pkg::GRAN_4K;
            r_cfg.low_size_offset  <= atw_pkg::SIZE_OFFSET_RESET;
            r_cfg.high_size_offset <= atw_pkg::SIZE_OFFSET_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                atw_pkg::REG_LOW_GRANULE:  r_cfg.low_granule      <= pwdata[1:0];
                atw_pkg::REG_HIGH_GRANULE: r_cfg.high_granule     <= pwdata[1:0];
                atw_pkg::REG_LOW_OFFSET:   r_cfg.low_size_offset  <= pwdata[5:0];
                atw_pkg::REG_HIGH_OFFSET:  r_cfg.high_size_offset <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            atw_pkg::REG_LOW_GRANULE:  prdata[1:0] = r_cfg.low_granule;
            atw_pkg::REG_HIGH_GRANULE: prdata[1:0] = r_cfg.high_granule;
            atw_pkg::REG_LOW_OFFSET:   prdata[5:0] = r_cfg.low_size_offset;
            atw_pkg::REG_HIGH_OFFSET:  prdata[5:0] = r_cfg.high_size_offset;
            default:                   prdata      = '0;
        endcase
    end

endmodule

FILE: rtl/atw_step.sv
// One walk step: decodes a request or a returned descriptor, forms the next
// descriptor address or the final translation, and gives the next walk state.
// Depends on atw_pkg for item, state and configuration types and codes.
module atw_step #(
    parameter int PA_BITS = atw_pkg::PA_BITS_DEFAULT
) (
    input  atw_pkg::t_in_item  i_item,
    input  atw_pkg::t_cfg      i_cfg,
    input  atw_pkg::t_walk     i_walk,
    output atw_pkg::t_walk     o_walk,
    output logic               o_res_vld,
    output atw_pkg::t_out_item o_res
);

    localparam logic [63:0] PaMask = (64'd1 << PA_BITS) - 64'd1;

    logic        hi;
    logic [1:0]  req_gran;
    logic [6:0]  req_width;
    logic [1:0]  req_lvl;
    logic        req_ok;

    logic        ag_gran;
    logic [1:0]  ag_lvl;
    logic [63:0] ag_va;
    logic [63:0] ag_base;
    logic [12:0] ag_idx;
    logic [4:0]  ag_align;
    logic [63:0] ag_addr;

    logic [1:0]  d_type;
    logic [4:0]  fin_lo;
    logic [2:0]  fin_ps;
    logic [63:0] fin_mask;
    logic [63:0] fin_pa;
    logic        is_fin;
    logic        is_cont;

    always_comb begin
        hi        = &i_item.virt_addr[63:47];
        req_gran  = hi ? i_cfg.high_granule : i_cfg.low_granule;
        req_width = 7'd64 - {1'b0, (hi ? i_cfg.high_size_offset : i_cfg.low_size_offset)};
        req_ok    = 1'b1;
        req_lvl   = 2'd0;
        case (req_gran)
            atw_pkg::GRAN_4K:  req_lvl = (req_width == atw_pkg::VA_WIDTH_4K_3LVL)  ? 2'd1 : 2'd0;
            atw_pkg::GRAN_64K: req_lvl = (req_width == atw_pkg::VA_WIDTH_64K_2LVL) ? 2'd2 : 2'd1;
            default:           req_ok  = 1'b0;
        endcase

        if (i_item.action == atw_pkg::ACT_DATA) begin
            ag_gran = i_walk.granule;
            ag_lvl  = i_walk.level + 2'd1;
            ag_va   = i_walk.vaddr;
            ag_base = i_item.read_data;
        end else begin
            ag_gran = req_gran[0];
            ag_lvl  = req_lvl;
            ag_va   = i_item.virt_addr;
            ag_base = {16'b0, i_item.table_base};
        end
    end

    always_comb begin
        if (!ag_gran) begin
            ag_align = 5'd12;
            case (ag_lvl)
                2'd0:    ag_idx = {4'b0, ag_va[47:39]};
                2'd1:    ag_idx = {4'b0, ag_va[38:30]};
                2'd2:    ag_idx = {4'b0, ag_va[29:21]};
                default: ag_idx = {4'b0, ag_va[20:12]};
            endcase
        end else begin
            case (ag_lvl)
                2'd0, 2'd1: begin
                    ag_align = 5'd9;
                    ag_idx   = {7'b0, ag_va[47:42]};
                end
                2'd2: begin
                    ag_align = 5'd16;
                    ag_idx   = ag_va[41:29];
                end
                default: begin
                    ag_align = 5'd16;
                    ag_idx   = ag_va[28:16];
                end
            endcase
        end
        ag_addr = (ag_base & PaMask & ~((64'd1 << ag_align) - 64'd1))
                | {48'b0, ag_idx, 3'b0};
    end

    always_comb begin
        d_type = i_item.read_data[1:0];
        if (!i_walk.granule) begin
            case (i_walk.level)
                2'd1: begin
                    fin_lo = 5'd30;
                    fin_ps = atw_pkg::PS_1G;
                end
                2'd2: begin
                    fin_lo = 5'd21;
                    fin_ps = atw_pkg::PS_2M;
                end
                default: begin
                    fin_lo = 5'd12;
                    fin_ps = atw_pkg::PS_4K;
                end
            endcase
            is_fin = ((i_walk.level == 2'd3) && (d_type == atw_pkg::DESC_TABLE))
                  || ((d_type == atw_pkg::DESC_BLOCK)
                      && ((i_walk.level == 2'd1) || (i_walk.level == 2'd2)));
        end else begin
            if (i_walk.level == 2'd2) begin
                fin_lo = 5'd29;
                fin_ps = atw_pkg::PS_512M;
            end else begin
                fin_lo = 5'd16;
                fin_ps = atw_pkg::PS_64K;
            end
            is_fin = ((i_walk.level == 2'd3) && (d_type == atw_pkg::DESC_TABLE))
                  || ((d_type == atw_pkg::DESC_BLOCK) && (i_walk.level == 2'd2));
        end
        is_cont  = (i_walk.level != 2'd3) && (d_type == atw_pkg::DESC_TABLE);
        fin_mask = (64'd1 << fin_lo) - 64'd1;
        fin_pa   = (i_item.read_data & PaMask & ~fin_mask) | (i_walk.vaddr & fin_mask);
    end

    always_comb begin
        o_walk    = i_walk;
        o_res_vld = 1'b0;
        o_res     = '0;
        o_res.kind = atw_pkg::KIND_FAULT;
        if (i_item.action == atw_pkg::ACT_REQUEST) begin
            o_res_vld   = 1'b1;
            o_walk.busy = 1'b0;
            if (req_ok) begin
                o_walk.busy          = 1'b1;
                o_walk.level         = req_lvl;
                o_walk.granule       = req_gran[0];
                o_walk.vaddr         = i_item.virt_addr;
                o_res.kind           = atw_pkg::KIND_READ;
                o_res.read_address   = ag_addr[47:0];
            end
        end else if (i_walk.busy) begin
            o_res_vld   = 1'b1;
            o_walk.busy = 1'b0;
            if (!i_item.read_error) begin
                if (is_fin) begin
                    o_res.kind      = atw_pkg::KIND_DONE;
                    o_res.phys_addr = fin_pa[47:0];
                    o_res.page_size = fin_ps;
                end else if (is_cont) begin
                    o_walk.busy        = 1'b1;
                    o_walk.level       = ag_lvl;
                    o_res.kind         = atw_pkg::KIND_READ;
                    o_res.read_address = ag_addr[47:0];
                end
            end
        end
    end

endmodule

FILE: rtl/aarch64_table_walker.sv
// Translation table walker top level: input register, walk state, result register.
// Throughput: one item per cycle while the output is not stalled; the walk state
// feeds back within that one step. Reset (synchronous, active low) empties both
// registers, ends any walk and loads granules 4KB and size offsets 25. Depends on
// atw_pkg, atw_regs, atw_step.
module aarch64_table_walker #(
    parameter int PA_BITS = atw_pkg::PA_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  atw_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output atw_pkg::t_out_item              o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [atw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [atw_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [atw_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    atw_pkg::t_cfg      cfg;
    atw_pkg::t_in_item  r_in;
    logic               r_in_vld;
    atw_pkg::t_walk     r_walk;
    atw_pkg::t_walk     n_walk;
    atw_pkg::t_out_item r_out;
    logic               r_out_vld;
    atw_pkg::t_out_item n_out;
    logic               n_out_vld;
    logic               advance;

    atw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    atw_step #(
        .PA_BITS (PA_BITS)
    ) u_step (
        .i_item    (r_in),
        .i_cfg     (cfg),
        .i_walk    (r_walk),
        .o_walk    (n_walk),
        .o_res_vld (n_out_vld),
        .o_res     (n_out)
    );

    assign advance     = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_in_vld && !advance;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (r_in_vld && advance) begin
            r_walk <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld && n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld && n_out_vld) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: bench/aarch64_table_walker_tb.sv
`timescale 1ns / 1ps
// Testbench for aarch64_table_walker: translate requests and descriptor returns go in,
// a scoreboard class predicts each result and checks it field by field.
// Depends on atw_pkg and the walker RTL only.
module aarch64_table_walker_tb;
    import atw_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 600;
    localparam int PHASES         = 10;
    localparam int SETTLE_CYCLES  = 3;
    localparam int REPORT_CAP     = 100;

    localparam logic [63:0] OUT_MASK = (64'd1 << 48) - 64'd1;
    localparam logic [63:0] PA_MASK  = (64'd1 << PA_BITS_DEFAULT) - 64'd1;

    localparam logic [1:0] GRAN_16K      = 2'd2;
    localparam logic [1:0] GRAN_RESERVED = 2'd3;
    localparam logic [5:0] OFFSET_4K_3LVL  = 6'(7'd64 - VA_WIDTH_4K_3LVL);
    localparam logic [5:0] OFFSET_64K_2LVL = 6'(7'd64 - VA_WIDTH_64K_2LVL);

    class walk_tracker;
        t_cfg        regs;
        bit          walking;
        logic [63:0] vaddr;
        bit          gran64k;
        logic [1:0]  level;
        t_out_item   pending_results[$];
        int          errors;

        function new();
            regs.low_granule      = GRAN_4K;
            regs.high_granule     = GRAN_4K;
            regs.low_size_offset  = SIZE_OFFSET_RESET;
            regs.high_size_offset = SIZE_OFFSET_RESET;
            walking = 0;
            vaddr   = '0;
            gran64k = 0;
            level   = '0;
            errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_LOW_GRANULE:  regs.low_granule      = value[1:0];
                REG_HIGH_GRANULE: regs.high_granule     = value[1:0];
                REG_LOW_OFFSET:   regs.low_size_offset  = value[5:0];
                REG_HIGH_OFFSET:  regs.high_size_offset = value[5:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mask_from(int lo);
            return PA_MASK & ~((64'd1 << lo) - 64'd1);
        endfunction

        function logic [47:0] entry_addr(logic [63:0] base, bit g64, logic [1:0] lvl,
                                         logic [63:0] va);
            logic [63:0] idx;
            logic [63:0] addr;
            int          align;
            if (!g64) begin
                idx   = (va >> (39 - 9 * int'(lvl))) & 64'h1FF;
                align = 12;
            end else if (lvl <= 2'd1) begin
                idx   = (va >> 42) & 64'h3F;
                align = 9;
            end else begin
                idx   = (va >> ((lvl == 2'd2) ? 29 : 16)) & 64'h1FFF;
                align = 16;
            end
            addr = ((base & mask_from(align)) | (idx << 3)) & OUT_MASK;
            return addr[47:0];
        endfunction

        function t_out_item make_result(t_kind k, logic [47:0] ra, logic [47:0] pa,
                                        logic [2:0] ps);
            t_out_item r;
            r.kind         = k;
            r.read_address = ra;
            r.phys_addr    = pa;
            r.page_size    = ps;
            return r;
        endfunction

        function t_out_item end_walk(logic [63:0] d, int lo, logic [2:0] ps);
            logic [63:0] pa;
            pa = ((d & mask_from(lo)) | (vaddr & ((64'd1 << lo) - 64'd1))) & OUT_MASK;
            walking = 0;
            return make_result(KIND_DONE, '0, pa[47:0], ps);
        endfunction

        function t_out_item fault_walk();
            walking = 0;
            return make_result(KIND_FAULT, '0, '0, PS_4K);
        endfunction

        function t_out_item request_step(t_in_item it);
            logic [1:0] g;
            logic [6:0] width;
            bit         hi;
            hi      = &it.virt_addr[63:47];
            g       = hi ? regs.high_granule : regs.low_granule;
            width   = 7'd64 - {1'b0, hi ? regs.high_size_offset : regs.low_size_offset};
            walking = 0;
            if (g == GRAN_4K) begin
                level = (width == VA_WIDTH_4K_3LVL) ? 2'd1 : 2'd0;
            end else if (g == GRAN_64K) begin
                level = (width == VA_WIDTH_64K_2LVL) ? 2'd2 : 2'd1;
            end else begin
                return fault_walk();
            end
            gran64k = (g == GRAN_64K);
            vaddr   = it.virt_addr;
            walking = 1;
            return make_result(KIND_READ, entry_addr({16'd0, it.table_base}, gran64k, level, vaddr),
                               '0, PS_4K);
        endfunction

        function t_out_item descriptor_step(t_in_item it);
            logic [63:0] d;
            logic [1:0]  t;
            d = it.read_data;
            t = d[1:0];
            if (it.read_error) return fault_walk();
            if (!gran64k) begin
                if (level == 2'd3) begin
                    if (t == DESC_TABLE) return end_walk(d, 12, PS_4K);
                    return fault_walk();
                end
                if (t == DESC_BLOCK && level == 2'd1) return end_walk(d, 30, PS_1G);
                if (t == DESC_BLOCK && level == 2'd2) return end_walk(d, 21, PS_2M);
            end else begin
                if (level == 2'd3) begin
                    if (t == DESC_TABLE) return end_walk(d, 16, PS_64K);
                    return fault_walk();
                end
                if (t == DESC_BLOCK && level == 2'd2) return end_walk(d, 29, PS_512M);
            end
            if (t != DESC_TABLE) return fault_walk();
            level = level + 2'd1;
            return make_result(KIND_READ, entry_addr(d, gran64k, level, vaddr), '0, PS_4K);
        endfunction

        function void note_input(t_in_item it);
            if (it.action == ACT_DATA) begin
                if (walking) pending_results.push_back(descriptor_step(it));
            end else begin
                pending_results.push_back(request_step(it));
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < REPORT_CAP)
                $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report("result with none pending, kind", got.kind, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind) report("kind", got.kind, want.kind);
            if (got.read_address != want.read_address)
                report("read_address", got.read_address, want.read_address);
            if (got.phys_addr != want.phys_addr) report("phys_addr", got.phys_addr, want.phys_addr);
            if (got.page_size != want.page_size) report("page_size", got.page_size, want.page_size);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    walk_tracker tracker;
    bit          quiet;
    int          item_count;

    aarch64_table_walker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) tracker.check_result(o_out_item);
            if (i_in_valid && !o_in_stall) tracker.note_input(i_in_item);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("[aarch64_table_walker] ERROR");
        $finish;
    end

    initial begin : out_stall_gen
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left  = $urandom_range(0, 11);
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] random_va();
        logic [63:0] va;
        int          pick;
        va   = rand64();
        pick = $urandom_range(0, 9);
        if (pick < 5) va[63:47] = '1;
        else if (pick < 9) va[63] = 1'b0;
        return va;
    endfunction

    function automatic t_in_item request_item(logic [63:0] va, logic [47:0] base);
        t_in_item it;
        it.action     = ACT_REQUEST;
        it.virt_addr  = va;
        it.table_base = base;
        it.read_data  = rand64();
        it.read_error = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_in_item descriptor_item(logic [63:0] d, logic err);
        t_in_item    it;
        logic [63:0] r;
        r             = rand64();
        it.action     = ACT_DATA;
        it.virt_addr  = rand64();
        it.table_base = r[47:0];
        it.read_data  = d;
        it.read_error = err;
        return it;
    endfunction

    function automatic t_in_item random_request();
        logic [63:0] base;
        base = rand64();
        return request_item(random_va(), base[47:0]);
    endfunction

    function automatic t_in_item random_descriptor();
        logic [63:0] d;
        int          pick;
        d    = rand64();
        pick = $urandom_range(0, 19);
        if (pick == 0) return descriptor_item(d, 1'b1);
        if (pick <= 2) d[0] = 1'b0;
        else if (pick <= 6) d[1:0] = DESC_BLOCK;
        else d[1:0] = DESC_TABLE;
        return descriptor_item(d, 1'b0);
    endfunction

    function automatic logic [1:0] pick_granule();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return GRAN_4K;
        if (r < 9) return GRAN_64K;
        return ($urandom_range(0, 1) == 0) ? GRAN_16K : GRAN_RESERVED;
    endfunction

    function automatic logic [5:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return OFFSET_4K_3LVL;
            1: return OFFSET_64K_2LVL;
            2: return 6'd0;
            3: return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic sender_pause();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n          = $urandom_range(1, 12);
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input t_in_item it);
        sender_pause();
        i_in_item  = it;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [1:0] lg, logic [1:0] hg, logic [5:0] lo, logic [5:0] ho);
        drain();
        apb_write(REG_LOW_GRANULE, ($urandom << 2) | lg);
        apb_write(REG_HIGH_GRANULE, ($urandom << 2) | hg);
        apb_write(REG_LOW_OFFSET, ($urandom << 6) | lo);
        apb_write(REG_HIGH_OFFSET, ($urandom << 6) | ho);
    endtask

    task automatic run_walk();
        send_item(random_request());
        item_count++;
        while (tracker.walking) begin
            if ($urandom_range(0, 24) == 0) send_item(random_request());
            else send_item(random_descriptor());
            item_count++;
        end
    endtask

    initial begin : stimulus
        int p;
        int stop;
        tracker    = new();
        quiet      = 0;
        item_count = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: 4KB granule, 39-bit space, walk starts at level 1
        send_item(request_item(64'h0, '1));
        send_item(descriptor_item('1, 1'b0));
        send_item(descriptor_item('1, 1'b0));
        send_item(descriptor_item('1, 1'b0));
        send_item(request_item('1, '0));
        send_item(descriptor_item(64'h0000_1234_4000_0001, 1'b0));
        send_item(request_item(64'h0000_7FFF_FFFF_FFFF, 48'h0000_0000_1000));
        send_item(descriptor_item(64'h0000_0000_2000_0003, 1'b0));
        send_item(descriptor_item(64'hFFF0_0000_0060_0001, 1'b0));
        send_item(request_item(64'hFFFF_8000_0000_0000, 48'hABCD_EF01_2345));
        send_item(descriptor_item(64'h3, 1'b1));
        send_item(request_item(64'h0000_0012_3456_789A, 48'h0000_8000_0000));
        send_item(descriptor_item(64'hFFFF_FFFF_FFFF_FFFC, 1'b0));
        send_item(descriptor_item(rand64(), 1'b0));
        send_item(request_item(64'h0000_0040_0000_0000, 48'h1111_2222_3333));
        send_item(request_item(64'hFFFF_FFC0_0000_0000, 48'h4444_5555_6666));
        send_item(descriptor_item(64'h0000_0000_0000_0002, 1'b0));
        send_item(request_item(64'h0000_0055_AAAA_5555, 48'h7777_8888_9000));
        send_item(descriptor_item(64'h0000_0000_0300_0003, 1'b0));
        send_item(descriptor_item(64'h0000_0000_0400_0003, 1'b0));
        send_item(descriptor_item(64'h0000_0000_0500_0001, 1'b0));

        // 64KB granule, 42-bit space below; unsupported granule above
        configure(GRAN_64K, GRAN_16K, OFFSET_64K_2LVL, 6'd0);
        send_item(request_item(64'hFFFF_8000_1234_0000, 48'h0000_0001_0000));
        send_item(request_item(64'h0000_4321_8765_ABCD, 48'hFFFF_FFFF_FFFF));
        send_item(descriptor_item(64'h0000_ABCD_E000_0001, 1'b0));
        send_item(request_item(64'h0000_0123_4567_89AB, 48'h0000_0002_0000));
        send_item(descriptor_item(64'h0000_0000_0003_0003, 1'b0));
        send_item(descriptor_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(GRAN_4K, GRAN_64K, 6'd63, 6'd0);
                1: configure(GRAN_64K, GRAN_4K, 6'd0, OFFSET_4K_3LVL);
                2: configure(GRAN_RESERVED, GRAN_64K, OFFSET_64K_2LVL, OFFSET_64K_2LVL);
                default: configure(pick_granule(), pick_granule(), pick_offset(), pick_offset());
            endcase
            quiet = (p == PHASES - 1);
            stop  = item_count + ITEM_TARGET / PHASES;
            while (item_count < stop) begin
                if ($urandom_range(0, 11) == 0) send_item(descriptor_item(rand64(), 1'b0));
                run_walk();
            end
        end

        drain();
        if (tracker.errors == 0) begin
            $display("[aarch64_table_walker] OK");
        end else begin
            $display("[aarch64_table_walker] ERROR");
        end
        $finish;
    end

endmodule
